// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file zyz_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, off during reset.
`define ZYZ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zyz assertion failed");

// Implication checked in the next cycle, off during reset.
`define ZYZ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zyz assertion failed");

// Implication checked in the next cycle, live during reset.
`define ZYZ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("zyz assertion failed");

`endif

// ===== rtl/zyz_pkg.sv =====
// Shared types, widths and constant functions for the ZYZ Euler converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package zyz_pkg;

  localparam int AXW = 34;   // rotated axis components, Q28
  localparam int DW  = 38;   // CORDIC datapath width
  localparam int KW  = 25;   // signed width of the gain inverse
  localparam int ANGLE_BITS = 16;  // output angle resolution, bits per turn

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } zyz_quat_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] alpha;
    logic [ANGLE_BITS-2:0] beta;
    logic [ANGLE_BITS-1:0] gamma;
  } zyz_angles_t;

  typedef struct packed {
    logic signed [AXW-1:0] zx;
    logic signed [AXW-1:0] zy;
    logic signed [AXW-1:0] zz;
    logic signed [AXW-1:0] xx;
    logic signed [AXW-1:0] xy;
    logic signed [AXW-1:0] xz;
  } zyz_axes_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] c;
    logic signed [DW-1:0] d;
  } zyz_vec_t;

  // atan(2^-i) in turns * 2^32, rounded
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // 1/K in Q24 for n micro-rotations
  function automatic logic [KW-1:0] gain_inv(input int n);
    logic [63:0] k2;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    logic [63:0] q;
    k2 = 64'd1 << 30;
    for (int i = 0; i < 32; i++) begin
      if (i < n) k2 = k2 + (k2 >> (2 * i));
    end
    v = k2 << 30;
    res = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    if (res == 0) res = 64'd1;
    rem = '0;
    q = '0;
    for (int b = 54; b >= 0; b--) begin
      rem = rem << 1;
      if (b == 54) rem = rem | 64'd1;
      if (rem >= res) begin
        rem = rem - res;
        q[b] = 1'b1;
      end
    end
    return q[KW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/zyz_front.sv =====
// Front end: accepts quaternions, forms the rotated z and x axes, queues them.
// Depends on zyz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module zyz_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire zyz_pkg::zyz_quat_t   quat,
  output logic                      q_vld,
  output zyz_pkg::zyz_axes_t        q_data,
  input  wire logic                 q_pop
);

  localparam int AXW = zyz_pkg::AXW;

  zyz_pkg::zyz_axes_t axes;
  zyz_pkg::zyz_axes_t slot [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       acc;

  logic signed [31:0] pxz, pwy, pyz, pwx, pxx, pyy, pzz, pxy, pwz;
  logic signed [AXW-1:0] one;

  always_comb begin
    one = AXW'(1) <<< 28;
    pxz = quat.x * quat.z;
    pwy = quat.w * quat.y;
    pyz = quat.y * quat.z;
    pwx = quat.w * quat.x;
    pxx = quat.x * quat.x;
    pyy = quat.y * quat.y;
    pzz = quat.z * quat.z;
    pxy = quat.x * quat.y;
    pwz = quat.w * quat.z;
    axes.zx = (AXW'(pxz) + AXW'(pwy)) <<< 1;
    axes.zy = (AXW'(pyz) - AXW'(pwx)) <<< 1;
    axes.zz = one - ((AXW'(pxx) + AXW'(pyy)) <<< 1);
    axes.xx = one - ((AXW'(pyy) + AXW'(pzz)) <<< 1);
    axes.xy = (AXW'(pxy) + AXW'(pwz)) <<< 1;
    axes.xz = (AXW'(pxz) - AXW'(pwy)) <<< 1;
  end

  assign full   = (cnt == 2'd2);
  assign acc    = push && !full;
  assign q_vld  = (cnt != 2'd0);
  assign q_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (acc) wr_ptr <= !wr_ptr;
      if (q_pop && q_vld) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(acc) - 2'(q_pop && q_vld);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) slot[wr_ptr] <= axes;
  end

endmodule
`default_nettype wire

// ===== rtl/zyz_cordic.sv =====
// Pipelined vectoring CORDIC with a companion pair, gain scaling and passenger bits.
// Depends on zyz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module zyz_cordic #(
  parameter int STEPS  = 16,
  parameter int PASS_W = 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               in_vld,
  input  wire zyz_pkg::zyz_vec_t  in_vec,
  input  wire logic [PASS_W-1:0]  in_pass,
  output logic                    out_vld,
  output zyz_pkg::zyz_vec_t       out_vec,
  output logic [31:0]             out_ang,
  output logic [PASS_W-1:0]       out_pass
);

  localparam int DW   = zyz_pkg::DW;
  localparam int KW   = zyz_pkg::KW;
  localparam int N    = (STEPS > 32) ? 32 : STEPS;
  localparam int LO_W = 19;
  localparam int HI_W = DW - LO_W;
  localparam logic signed [KW-1:0] KINV = zyz_pkg::gain_inv(N);

  zyz_pkg::zyz_vec_t v_q [0:N];
  logic [31:0]       a_q [0:N];
  logic              z_q [0:N];
  logic              vld_q [0:N];
  logic [PASS_W-1:0] p_q [0:N];

  always_ff @(posedge clk) begin
    if (rst) vld_q[0] <= 1'b0;
    else if (adv) vld_q[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z_q[0] <= (in_vec.x == '0) && (in_vec.y == '0);
      p_q[0] <= in_pass;
      if (in_vec.x[DW-1]) begin
        v_q[0].x <= -in_vec.x;
        v_q[0].y <= -in_vec.y;
        v_q[0].c <= -in_vec.c;
        v_q[0].d <= -in_vec.d;
        a_q[0]   <= 32'h8000_0000;
      end else begin
        v_q[0] <= in_vec;
        a_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [31:0] AT = zyz_pkg::atan_turn(i);
    zyz_pkg::zyz_vec_t vn;
    logic [31:0]       an;

    always_comb begin
      vn = v_q[i];
      an = a_q[i];
      if (!z_q[i]) begin
        if (!v_q[i].y[DW-1]) begin
          vn.x = v_q[i].x + (v_q[i].y >>> i);
          vn.y = v_q[i].y - (v_q[i].x >>> i);
          vn.c = v_q[i].c + (v_q[i].d >>> i);
          vn.d = v_q[i].d - (v_q[i].c >>> i);
          an   = a_q[i] + AT;
        end else begin
          vn.x = v_q[i].x - (v_q[i].y >>> i);
          vn.y = v_q[i].y + (v_q[i].x >>> i);
          vn.c = v_q[i].c - (v_q[i].d >>> i);
          vn.d = v_q[i].d + (v_q[i].c >>> i);
          an   = a_q[i] - AT;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld_q[i+1] <= 1'b0;
      else if (adv) vld_q[i+1] <= vld_q[i];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        v_q[i+1] <= vn;
        a_q[i+1] <= an;
        z_q[i+1] <= z_q[i];
        p_q[i+1] <= p_q[i];
      end
    end
  end

  // gain scaling: split multiply, then sum and round
  logic signed [DW-1:0]        raw [0:3];
  logic signed [HI_W+KW-1:0]   phi [0:3];
  logic signed [LO_W+KW:0]     plo [0:3];
  logic signed [HI_W+KW-1:0]   phi_q [0:3];
  logic signed [LO_W+KW:0]     plo_q [0:3];
  zyz_pkg::zyz_vec_t           s1_vec;
  logic [31:0]                 s1_ang;
  logic                        s1_z;
  logic                        s1_vld;
  logic [PASS_W-1:0]           s1_pass;
  logic signed [DW-1:0]        scl [0:3];
  logic signed [DW-1:0]        s1_raw [0:3];

  always_comb begin
    raw[0] = v_q[N].x;
    raw[1] = v_q[N].y;
    raw[2] = v_q[N].c;
    raw[3] = v_q[N].d;
    s1_raw[0] = s1_vec.x;
    s1_raw[1] = s1_vec.y;
    s1_raw[2] = s1_vec.c;
    s1_raw[3] = s1_vec.d;
  end

  for (genvar k = 0; k < 4; k++) begin : g_scale
    logic signed [63:0] sum;
    always_comb begin
      phi[k] = $signed(raw[k][DW-1:LO_W]) * KINV;
      plo[k] = $signed({1'b0, raw[k][LO_W-1:0]}) * KINV;
      sum    = (64'(phi_q[k]) <<< LO_W) + 64'(plo_q[k]) + (64'sd1 <<< 23);
      scl[k] = s1_z ? s1_raw[k] : DW'(sum >>> 24);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        phi_q[k] <= phi[k];
        plo_q[k] <= plo[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      s1_vld  <= vld_q[N];
      out_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_vec    <= v_q[N];
      s1_ang    <= a_q[N];
      s1_z      <= z_q[N];
      s1_pass   <= p_q[N];
      out_vec.x <= scl[0];
      out_vec.y <= scl[1];
      out_vec.c <= scl[2];
      out_vec.d <= scl[3];
      out_ang   <= s1_ang;
      out_pass  <= s1_pass;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/quaternion_to_zyz_euler.sv =====
// Top level: quaternion in, ZYZ Euler angles out, as two queues.
// Depends on zyz_pkg, zyz_front, zyz_cordic.
//
//   channel   handshake      payload
//   request   push / full    quat   (w, x, y, z, Q2.14)
//   result    pop / empty    angles (alpha, beta, gamma, turns)
//
// One quaternion per cycle sustained while results are popped. Each result passes
// through the three chained CORDIC pipelines, one stage per micro-rotation.
// A result not popped stalls the whole back pipeline; the two-entry front queue
// keeps accepting until it fills. Synchronous reset empties everything.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_zyz_euler #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire zyz_pkg::zyz_quat_t    quat,
  output logic                       empty,
  input  wire logic                  pop,
  output zyz_pkg::zyz_angles_t       angles
);

  localparam int DW = zyz_pkg::DW;
  localparam int AXW = zyz_pkg::AXW;
  localparam int ANGLE_BITS = zyz_pkg::ANGLE_BITS;
  localparam int DROP = 32 - ANGLE_BITS;
  localparam logic [32:0] RND = (ANGLE_BITS < 32) ? (33'd1 << (31 - ANGLE_BITS)) : 33'd0;
  localparam logic [32:0] MASK_A = (33'd1 << ANGLE_BITS) - 33'd1;
  localparam logic [32:0] MASK_B = (33'd1 << (ANGLE_BITS - 1)) - 33'd1;

  logic               adv;
  logic               q_vld;
  zyz_pkg::zyz_axes_t q_data;
  logic               res_vld;

  assign adv   = !res_vld || pop;
  assign empty = !res_vld;

  zyz_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .quat   (quat),
    .q_vld  (q_vld),
    .q_data (q_data),
    .q_pop  (adv)
  );

  // gamma: rotated z axis, companion is rotated x axis (xx, xy)
  zyz_pkg::zyz_vec_t      a_in, a_out;
  logic [2*DW-1:0]        a_pin, a_pout;
  logic                   a_vld;
  logic [31:0]            gamma;

  always_comb begin
    a_in.x = DW'(q_data.zx);
    a_in.y = DW'(q_data.zy);
    a_in.c = DW'(q_data.xx);
    a_in.d = DW'(q_data.xy);
    a_pin  = {DW'(q_data.zz), DW'(q_data.xz)};
  end

  zyz_cordic #(.STEPS(CORDIC_STEPS), .PASS_W(2*DW)) u_gamma (
    .clk (clk), .rst (rst), .adv (adv),
    .in_vld (q_vld), .in_vec (a_in), .in_pass (a_pin),
    .out_vld (a_vld), .out_vec (a_out), .out_ang (gamma), .out_pass (a_pout)
  );

  // beta: (zz, zx'), companion (xz, xx')
  zyz_pkg::zyz_vec_t      b_in, b_out;
  logic [DW+31:0]         b_pin, b_pout;
  logic                   b_vld;
  logic [31:0]            beta;

  always_comb begin
    b_in.x = $signed(a_pout[2*DW-1:DW]);
    b_in.y = a_out.x;
    b_in.c = $signed(a_pout[DW-1:0]);
    b_in.d = a_out.c;
    b_pin  = {a_out.d, gamma};
  end

  zyz_cordic #(.STEPS(CORDIC_STEPS), .PASS_W(DW+32)) u_beta (
    .clk (clk), .rst (rst), .adv (adv),
    .in_vld (a_vld), .in_vec (b_in), .in_pass (b_pin),
    .out_vld (b_vld), .out_vec (b_out), .out_ang (beta), .out_pass (b_pout)
  );

  // alpha: (xx'', xy'), no companion
  zyz_pkg::zyz_vec_t      c_in, c_out;
  logic [63:0]            c_pin, c_pout;
  logic                   c_vld;
  logic [31:0]            alpha;

  always_comb begin
    c_in.x = b_out.d;
    c_in.y = $signed(b_pout[DW+31:32]);
    c_in.c = '0;
    c_in.d = '0;
    c_pin  = {b_pout[31:0], beta};
  end

  zyz_cordic #(.STEPS(CORDIC_STEPS), .PASS_W(64)) u_alpha (
    .clk (clk), .rst (rst), .adv (adv),
    .in_vld (b_vld), .in_vec (c_in), .in_pass (c_pin),
    .out_vld (c_vld), .out_vec (c_out), .out_ang (alpha), .out_pass (c_pout)
  );

  logic [32:0] qa, qb, qg;

  always_comb begin
    qa = (({1'b0, alpha} + RND) >> DROP) & MASK_A;
    qb = (({1'b0, c_pout[31:0]} + RND) >> DROP) & MASK_B;
    qg = (({1'b0, c_pout[63:32]} + RND) >> DROP) & MASK_A;
  end

  always_ff @(posedge clk) begin
    if (rst) res_vld <= 1'b0;
    else if (adv) res_vld <= c_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angles.alpha <= qa[ANGLE_BITS-1:0];
      angles.beta  <= qb[ANGLE_BITS-2:0];
      angles.gamma <= qg[ANGLE_BITS-1:0];
    end
  end

  logic unused_ok;
  assign unused_ok = ^{c_out, a_out.y, b_out.x, b_out.y, b_out.c, AXW'(0)};

endmodule
`default_nettype wire

// ===== rtl/zyz_checker.sv =====
// Port-level checks for quaternion_to_zyz_euler, attached by bind.
// Depends on zyz_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module zyz_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 push,
  input wire logic                 full,
  input wire zyz_pkg::zyz_quat_t   quat,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire zyz_pkg::zyz_angles_t angles
);

  logic unused_ok;
  assign unused_ok = ^quat;

  `ZYZ_ASSERT_NEXT_ALWAYS(a_reset_clear, clk, rst, empty && !full)
  `ZYZ_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(angles))
  `ZYZ_ASSERT_SAME(a_full_after_request, clk, rst, $rose(full), $past(push))

endmodule

bind quaternion_to_zyz_euler zyz_checker u_zyz_checker (.*);
`default_nettype wire
